// ===== rtl/pcuf_pkg.sv =====
// Shared types and constants for the parity constraint union-find unit.
// Used by the root walker and the top level; depends on nothing.
package pcuf_pkg;

  localparam int ID_W  = 10;
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic start;
    logic wr;
  } walk_cmd_t;

  typedef struct packed {
    logic init_done;
    logic done;
  } walk_stat_t;

endpackage

// ===== rtl/pcuf_walker.sv =====
// Parent table memory with clearing pass after reset, root walk and link write.
// Depends on pcuf_pkg.
module pcuf_walker import pcuf_pkg::*; #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  walk_cmd_t                cmd,
  input  logic [$clog2(DEPTH)-1:0] node,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_data,
  output walk_stat_t               stat,
  output logic [$clog2(DEPTH)-1:0] root
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic [1:0] W_CLR  = 2'd0;
  localparam logic [1:0] W_IDLE = 2'd1;
  localparam logic [1:0] W_WALK = 2'd2;

  logic [AW-1:0] mem [DEPTH];
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          at_root;

  assign at_root = (state_r == W_WALK) && (rd_q == cur_r);
  assign rd_addr = (state_r == W_WALK) ? rd_q : node;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cur_nxt   = cur_r;
    case (state_r)
      W_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST) begin
          state_nxt = W_IDLE;
        end
      end
      W_IDLE: begin
        if (cmd.start) begin
          cur_nxt   = node;
          state_nxt = W_WALK;
        end
      end
      W_WALK: begin
        if (at_root) begin
          state_nxt = W_IDLE;
        end else begin
          cur_nxt = rd_q;
        end
      end
      default: begin
        state_nxt = W_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == W_CLR) begin
      mem[clr_r] <= clr_r;
    end else if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign stat.init_done = (state_r != W_CLR);
  assign stat.done      = at_root;
  assign root           = cur_r;

endmodule

// ===== rtl/parity_constraint_union_find_unit.sv =====
// Channel | dir | handshake                  | payload
// in      | in  | in_tvalid / in_tready      | tdata: left_node, right_node; tuser: parity_even
// out     | out | out_tvalid / out_tready    | tdata: conflict, stopped, accepted_count
//
// An item takes one root walk per lookup: 2 walks when it conflicts,
// 6 when it links, each walk going through the single parent memory.
// Ignored items (stopped, or node id not below NODES) take no walks.
// After reset the parent table is cleared; in_tready stays low meanwhile.
// in_tready is high only between items; a result waiting on out_tready holds the sequencer.
// Top level of the parity constraint union-find unit; depends on pcuf_pkg, pcuf_walker.
module parity_constraint_union_find_unit import pcuf_pkg::*; #(
  parameter int NODES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // left_node[9:0], right_node[19:10], zero pad
  input  logic        in_tuser,   // parity_even
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // conflict[0], stopped[1], accepted_count[17:2], zero pad
);

  localparam int DEPTH = 2 * NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] NOFF = AW'(NODES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [AW-1:0]    a_r, a_nxt;
  logic [AW-1:0]    b_r, b_nxt;
  logic             even_r, even_nxt;
  logic [AW-1:0]    root0_r, root0_nxt;
  logic             stop_r, stop_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             conf_r, conf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_conf_r, out_conf_nxt;
  logic             out_stop_r, out_stop_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic [ID_W-1:0]  in_left, in_right;
  logic             in_ok;
  logic             in_fire;
  logic [AW-1:0]    sel_node;
  walk_cmd_t        cmd;
  walk_stat_t       stat;
  logic [AW-1:0]    root;

  assign in_left   = in_tdata[ID_W-1:0];
  assign in_right  = in_tdata[2*ID_W-1:ID_W];
  assign in_ok     = (32'(in_left) < NODES) && (32'(in_right) < NODES);
  assign in_tready = (state_r == S_IDLE) && stat.init_done;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    case (step_r)
      3'd0:    sel_node = a_r;
      3'd1:    sel_node = even_r ? b_r + NOFF : b_r;
      3'd2:    sel_node = a_r;
      3'd3:    sel_node = even_r ? b_r : b_r + NOFF;
      3'd4:    sel_node = even_r ? a_r + NOFF : b_r;
      3'd5:    sel_node = even_r ? b_r + NOFF : a_r + NOFF;
      default: sel_node = a_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    even_nxt      = even_r;
    root0_nxt     = root0_r;
    stop_nxt      = stop_r;
    cnt_nxt       = cnt_r;
    conf_nxt      = conf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_conf_nxt  = out_conf_r;
    out_stop_nxt  = out_stop_r;
    out_cnt_nxt   = out_cnt_r;
    cmd.start     = 1'b0;
    cmd.wr        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          a_nxt    = AW'(in_left);
          b_nxt    = AW'(in_right);
          even_nxt = in_tuser;
          conf_nxt = 1'b0;
          step_nxt = 3'd0;
          state_nxt = (stop_r || !in_ok) ? S_OUT : S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (stat.done) begin
          case (step_r)
            3'd1: begin
              if (root0_r == root) begin
                conf_nxt  = 1'b1;
                stop_nxt  = 1'b1;
                state_nxt = S_OUT;
              end else begin
                step_nxt  = 3'd2;
                state_nxt = S_START;
              end
            end
            3'd3: begin
              cmd.wr    = 1'b1;
              step_nxt  = 3'd4;
              state_nxt = S_START;
            end
            3'd5: begin
              cmd.wr    = 1'b1;
              if (cnt_r != CNT_MAX) begin
                cnt_nxt = cnt_r + 1'b1;
              end
              state_nxt = S_OUT;
            end
            default: begin
              root0_nxt = root;
              step_nxt  = step_r + 1'b1;
              state_nxt = S_START;
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_conf_nxt  = conf_r;
          out_stop_nxt  = stop_r;
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      stop_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      stop_r      <= stop_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    even_r     <= even_nxt;
    root0_r    <= root0_nxt;
    conf_r     <= conf_nxt;
    out_conf_r <= out_conf_nxt;
    out_stop_r <= out_stop_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  pcuf_walker #(
    .DEPTH (DEPTH)
  ) u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .node    (sel_node),
    .wr_addr (root0_r),
    .wr_data (root),
    .stat    (stat),
    .root    (root)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_cnt_r, out_stop_r, out_conf_r};

`ifndef SYNTH
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("stop flag cleared");

  a_cnt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> $stable(cnt_r))
    else $error("count changed after stop");

  a_conf_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_conf_r) |-> out_stop_r)
    else $error("conflict reported without stop");

  a_wr_linking: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (state_r == S_WAIT && stat.done && !stop_r))
    else $error("table write outside a link step");
`endif

endmodule
